// ===== rtl/afc_pkg.sv =====
// package for the aabb frustum cull core: widths, types, reset values
// and the quadrant helper; no dependencies
package afc_pkg;

  localparam int CoordWidth = 32;
  localparam int CfgIdxWidth = 3;
  localparam int CfgDataWidth = 64;
  localparam int ProdWidth = 64;
  localparam int SumWidth = 67;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_ROW0_A = 3'd0,
    REG_ROW0_B = 3'd1,
    REG_ROW1_A = 3'd2,
    REG_ROW1_B = 3'd3,
    REG_ROW2_A = 3'd4,
    REG_ROW2_B = 3'd5,
    REG_ROW3_A = 3'd6,
    REG_ROW3_B = 3'd7
  } cfg_reg_e;

  localparam logic [CfgDataWidth-1:0] CfgReset [8] = '{
    64'd65536, 64'd0, 64'd281474976710656, 64'd0,
    64'd0, 64'd65536, 64'd0, 64'd281474976710656
  };

  typedef logic signed [31:0] coef_t;
  typedef logic signed [SumWidth-1:0] sum_t;

  // matrix as coefficients [row][col]
  typedef coef_t mat_t [4][4];

  typedef struct packed {
    logic       valid;
    logic [2:0] bits;
  } ctl_t;

  // bit0 c < -w, bit1 c > w
  function automatic logic [1:0] quad(input sum_t c, input sum_t w);
    logic signed [SumWidth:0] s;
    logic signed [SumWidth:0] d;
    s = {c[SumWidth-1], c} + {w[SumWidth-1], w};
    d = {c[SumWidth-1], c} - {w[SumWidth-1], w};
    quad = {(d > 0), s[SumWidth]};
  endfunction

endpackage

// ===== rtl/afc_cfg.sv =====
// configuration register file, unpacks the matrix into coefficients
// depends on afc_pkg
module afc_cfg
  import afc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  output mat_t                    mat_o
);

  logic [CfgDataWidth-1:0] regs_q [8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) regs_q[i] <= CfgReset[i];
    end else if (cfg_we_i) begin
      regs_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        mat_o[r][c] = coef_t'(regs_q[r*2 + c/2][32*(c%2) +: 32]);
      end
    end
  end

endmodule

// ===== rtl/afc_datapath.sv =====
// four stage pipeline: products, sums, quadrant codes, decision
// depends on afc_pkg
module afc_datapath
  import afc_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  mat_t                         mat_i,
  input  logic                         valid_i,
  input  logic signed [CoordWidth-1:0] bmin_i [3],
  input  logic signed [CoordWidth-1:0] bmax_i [3],
  input  logic [2:0]                   bits_i,
  output logic                         valid_o,
  output logic                         culled_o,
  output logic [2:0]                   bits_o
);

  // stage 1: per-axis products for min and max coordinate, per column
  logic signed [ProdWidth-1:0] plo_q [3][4];
  logic signed [ProdWidth-1:0] phi_q [3][4];
  logic [3:0] pos_q [3];
  ctl_t c1_q, c2_q, c3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      c1_q <= '{valid: valid_i, bits: bits_i};
      c2_q <= c1_q;
      c3_q <= c2_q;
      valid_o <= c3_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int n = 0; n < 4; n++) begin
          plo_q[r][n] <= ProdWidth'(bmin_i[r]) * ProdWidth'(mat_i[r][n]);
          phi_q[r][n] <= ProdWidth'(bmax_i[r]) * ProdWidth'(mat_i[r][n]);
          pos_q[r][n] <= (mat_i[r][n] > 0);
        end
      end
    end
  end

  // stage 2: extremes and eight corners per column
  sum_t emin_q [4];
  sum_t emax_q [4];
  sum_t corn_q [8][4];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int n = 0; n < 4; n++) begin
        emin_q[n] <= (sum_t'(mat_i[3][n]) <<< 16)
          + sum_t'(pos_q[0][n] ? plo_q[0][n] : phi_q[0][n])
          + sum_t'(pos_q[1][n] ? plo_q[1][n] : phi_q[1][n])
          + sum_t'(pos_q[2][n] ? plo_q[2][n] : phi_q[2][n]);
        emax_q[n] <= (sum_t'(mat_i[3][n]) <<< 16)
          + sum_t'(pos_q[0][n] ? phi_q[0][n] : plo_q[0][n])
          + sum_t'(pos_q[1][n] ? phi_q[1][n] : plo_q[1][n])
          + sum_t'(pos_q[2][n] ? phi_q[2][n] : plo_q[2][n]);
        for (int k = 0; k < 8; k++) begin
          corn_q[k][n] <= (sum_t'(mat_i[3][n]) <<< 16)
            + sum_t'(k[0] ? phi_q[0][n] : plo_q[0][n])
            + sum_t'(k[1] ? phi_q[1][n] : plo_q[1][n])
            + sum_t'(k[2] ? phi_q[2][n] : plo_q[2][n]);
        end
      end
    end
  end

  // stage 3: quadrant and/or reductions per axis
  logic       wneg_q;
  logic [1:0] ea_q [3];
  logic [1:0] eo_q [3];
  logic [1:0] ka_q [3];
  logic [1:0] ko_q [3];

  always_ff @(posedge clk_i) begin
    logic [1:0] q;
    logic [1:0] a;
    logic [1:0] o;
    if (en_i) begin
      wneg_q <= emax_q[3][SumWidth-1];
      for (int i = 0; i < 3; i++) begin
        a = 2'b11;
        o = 2'b00;
        q = quad(emin_q[i], emin_q[3]); a &= q; o |= q;
        q = quad(emin_q[i], emax_q[3]); a &= q; o |= q;
        q = quad(emax_q[i], emin_q[3]); a &= q; o |= q;
        q = quad(emax_q[i], emax_q[3]); a &= q; o |= q;
        ea_q[i] <= a;
        eo_q[i] <= o;
        a = 2'b11;
        o = 2'b00;
        for (int k = 0; k < 8; k++) begin
          q = quad(corn_q[k][i], corn_q[k][3]);
          a &= q;
          o |= q;
        end
        ka_q[i] <= a;
        ko_q[i] <= o;
      end
    end
  end

  // stage 4: walk the axes in order
  always_ff @(posedge clk_i) begin
    logic [2:0] b;
    logic       cull;
    logic       done;
    if (en_i) begin
      b = c3_q.bits;
      cull = wneg_q;
      done = wneg_q;
      for (int i = 0; i < 3; i++) begin
        if (!done && b[i]) begin
          if (eo_q[i] == 2'b00) begin
            b[i] = 1'b0;
          end else if (ea_q[i] != 2'b00) begin
            cull = 1'b1;
            done = 1'b1;
          end else if (ko_q[i] == 2'b00) begin
            b[i] = 1'b0;
          end else if (ka_q[i] != 2'b00) begin
            cull = 1'b1;
            done = 1'b1;
          end
        end
      end
      culled_o <= cull;
      bits_o <= b;
    end
  end

endmodule

// ===== rtl/aabb_frustum_cull_core.sv =====
// aabb_frustum_cull_core: culls one axis-aligned box per cycle, unless
// stalled, against the clip volume of a configured 4x4 matrix
// Usage:
//   request channel: valid_i/stall_o with min/max corners (signed Q16.16)
//   and the plane mask cull_bits_in_i. A request is taken on a clock edge
//   with valid_i high and stall_o low.
//   result channel: valid_o/stall_i with culled_o and cull_bits_out_o,
//   taken on an edge with valid_o high and stall_i low.
//   configuration: cfg_we_i, cfg_idx_i, cfg_data_i write one matrix
//   register per cycle; write only while the block is idle.
// Throughput is one box per cycle while the result channel does not stall,
// set by the four register stages (products, sums, quadrant codes,
// decision) that all advance together.
// When stall_i is high and a result is waiting, the whole pipeline holds
// and stall_o rises; nothing is lost or repeated.
// Reset empties the pipeline and loads the identity matrix.
module aabb_frustum_cull_core
  import afc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  input  logic                    valid_i,
  output logic                    stall_o,
  input  logic signed [31:0]      min_x_i,
  input  logic signed [31:0]      min_y_i,
  input  logic signed [31:0]      min_z_i,
  input  logic signed [31:0]      max_x_i,
  input  logic signed [31:0]      max_y_i,
  input  logic signed [31:0]      max_z_i,
  input  logic [2:0]              cull_bits_in_i,
  output logic                    valid_o,
  input  logic                    stall_i,
  output logic                    culled_o,
  output logic [2:0]              cull_bits_out_o
);

  mat_t mat;
  logic en;
  logic signed [CoordWidth-1:0] bmin [3];
  logic signed [CoordWidth-1:0] bmax [3];

  assign en = !(valid_o && stall_i);
  assign stall_o = !en;

  assign bmin[0] = min_x_i[CoordWidth-1:0];
  assign bmin[1] = min_y_i[CoordWidth-1:0];
  assign bmin[2] = min_z_i[CoordWidth-1:0];
  assign bmax[0] = max_x_i[CoordWidth-1:0];
  assign bmax[1] = max_y_i[CoordWidth-1:0];
  assign bmax[2] = max_z_i[CoordWidth-1:0];

  afc_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .mat_o (mat)
  );

  afc_datapath u_dp (
    .clk_i,
    .rst_ni,
    .en_i     (en),
    .mat_i    (mat),
    .valid_i  (valid_i),
    .bmin_i   (bmin),
    .bmax_i   (bmax),
    .bits_i   (cull_bits_in_i),
    .valid_o  (valid_o),
    .culled_o (culled_o),
    .bits_o   (cull_bits_out_o)
  );

endmodule

// ===== rtl/afc_checker.sv =====
// port-level checks for aabb_frustum_cull_core, bound to the top level
// depends on afc_pkg
module afc_checker
  import afc_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_i,
  input logic       stall_o,
  input logic       valid_o,
  input logic       stall_i,
  input logic       culled_o,
  input logic [2:0] cull_bits_out_o
);

  // result stays while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(culled_o) && $stable(cull_bits_out_o))
    else $error("stalled result changed");

  // input stalls only when output blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("spurious stall");

  // result follows a request when no stall comes between
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o ##1 !stall_o ##1 !stall_o ##1 !stall_o |=> valid_o)
    else $error("result missing");

  // result only follows a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stall_o && !$past(valid_i, 4) && !$past(stall_o, 1) && !$past(stall_o, 2)
      && !$past(stall_o, 3) && !$past(stall_o, 4) && $past(rst_ni, 5) |-> !valid_o)
    else $error("invented result");

endmodule

bind aabb_frustum_cull_core afc_checker u_afc_checker (
  .clk_i,
  .rst_ni,
  .valid_i,
  .stall_o,
  .valid_o,
  .stall_i,
  .culled_o,
  .cull_bits_out_o
);
